>>> rtl/core/tsm_pkg.sv
// Shared constants, codes and types of the three-stack memory block.
`default_nettype none

package tsm_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int NUM_STACKS  = 3;
    localparam int MEM_WORDS   = STACK_DEPTH * NUM_STACKS;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 2;
    localparam int SEL_W  = 2;
    localparam int STAT_W = 2;
    localparam int ADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SORT    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DISPLAY = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

    // one cycle of memory traffic: one write and one read
    typedef struct packed {
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_data;
        logic                     rd_en;
        logic [ADDR_W-1:0]        rd_addr;
    } ram_req_t;

endpackage

`default_nettype wire

>>> rtl/core/tsm_stack_ram.sv
// Shared stack memory: one write port, one read port, registered read data.
`default_nettype none

module tsm_stack_ram
(
    input  wire logic                             clk,
    input  wire tsm_pkg::ram_req_t                req,
    output logic signed [tsm_pkg::DATA_W-1:0]     rd_data
);

    logic signed [tsm_pkg::DATA_W-1:0] mem [tsm_pkg::MEM_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/three_stacks_one_memory_with_sort_core.sv
// Top level: three stacks in one shared memory, with push, pop, sort and display.
//
// Input transfers (s_*) carry one command: s_tuser holds the operation and the
// stack number, s_tdata the value for a push. Result transfers (m_*) carry a
// status in m_tuser, a value in m_tdata and m_tlast on the final result of a
// command. Commands naming a stack past the last one give no result and change
// nothing. Push, pop and sort give one result; display gives one result per
// entry, top first, or one empty status for an empty stack.
// All state lives in one synchronous memory (one read and one write port); the
// per-stack counts sit in flip-flops. Commands are taken in the idle state only,
// so they run one at a time.
//   Push, pop and display of an empty stack: accept, then load the result.
//   Display of n entries: one memory read per entry.
//   Sort (insertion sort on the memory port): each step does at most one read
//   and one write of the memory.
// Reset empties all stacks (counts to zero) and leaves the memory as is. A result
// waits in the output register until taken; a command can be taken while it
// waits, and when the receiver stalls the block holds in its result state and
// takes nothing new.
`default_nettype none

module three_stacks_one_memory_with_sort_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic signed [tsm_pkg::DATA_W-1:0] s_tdata,  // [31:0] push_value
    input  wire logic [3:0]                        s_tuser,  // [1:0] func, [3:2] stack_select
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic signed [tsm_pkg::DATA_W-1:0]      m_tdata,  // [31:0] value
    output logic [tsm_pkg::STAT_W-1:0]             m_tuser,  // [1:0] status
    output logic                                   m_tlast   // last
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_RESULT   = 3'd1;
    localparam logic [2:0] ST_SORT_V   = 3'd2;
    localparam logic [2:0] ST_SORT_CMP = 3'd3;
    localparam logic [2:0] ST_SORT_PUT = 3'd4;

    localparam int IW = tsm_pkg::IDX_W;
    localparam int CW = tsm_pkg::CNT_W;
    localparam int AW = tsm_pkg::ADDR_W;

    // word address of entry idx in stack sel
    function automatic logic [AW-1:0] entry_addr(input logic [tsm_pkg::SEL_W-1:0] sel,
                                                 input logic [IW-1:0] idx);
        logic [AW-1:0] base;
        base = AW'(sel) * AW'(tsm_pkg::STACK_DEPTH);
        return base + AW'(idx);
    endfunction

    logic [2:0]                        state_reg, state_next;
    logic [tsm_pkg::FUNC_W-1:0]        func_reg, func_next;
    logic [tsm_pkg::SEL_W-1:0]         sel_reg, sel_next;
    logic [CW-1:0]                     count_reg [tsm_pkg::NUM_STACKS];
    logic [CW-1:0]                     count_next [tsm_pkg::NUM_STACKS];
    logic [IW-1:0]                     idx_reg, idx_next;   // display position, sort outer index
    logic [IW-1:0]                     j_reg, j_next;       // sort hole position
    logic signed [tsm_pkg::DATA_W-1:0] v_reg, v_next;       // sort key being inserted
    logic [tsm_pkg::STAT_W-1:0]        res_stat_reg, res_stat_next;
    logic                              res_mem_reg, res_mem_next;   // value from memory
    logic                              res_last_reg, res_last_next;

    logic                              m_valid_reg, m_valid_next;
    logic signed [tsm_pkg::DATA_W-1:0] m_data_reg, m_data_next;
    logic [tsm_pkg::STAT_W-1:0]        m_user_reg, m_user_next;
    logic                              m_last_reg, m_last_next;

    tsm_pkg::ram_req_t                 ram_req;
    logic signed [tsm_pkg::DATA_W-1:0] ram_rdata;

    tsm_stack_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rdata)
    );

    logic [tsm_pkg::FUNC_W-1:0] in_func;
    logic [tsm_pkg::SEL_W-1:0]  in_sel;
    logic [CW-1:0]              in_cnt;
    logic [CW-1:0]              cur_cnt;
    logic                       slot_free;
    logic [IW-1:0]              i_plus;
    logic [IW-1:0]              j_minus;

    assign in_func   = s_tuser[1:0];
    assign in_sel    = s_tuser[3:2];
    assign in_cnt    = count_reg[in_sel];
    assign cur_cnt   = count_reg[sel_reg];
    assign slot_free = !m_valid_reg || m_tready;
    assign i_plus    = idx_reg + IW'(1);
    assign j_minus   = j_reg - IW'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        sel_next      = sel_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        v_next        = v_reg;
        res_stat_next = res_stat_reg;
        res_mem_next  = res_mem_reg;
        res_last_next = res_last_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;

        ram_req         = '0;
        ram_req.wr_data = v_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (int'(in_sel) < tsm_pkg::NUM_STACKS))
                begin
                    func_next     = in_func;
                    sel_next      = in_sel;
                    res_stat_next = tsm_pkg::STAT_OK;
                    res_mem_next  = 1'b0;
                    res_last_next = 1'b1;
                    state_next    = ST_RESULT;
                    unique case (in_func)
                        tsm_pkg::FUNC_PUSH:
                        begin
                            if (in_cnt == CW'(tsm_pkg::STACK_DEPTH))
                            begin
                                res_stat_next = tsm_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = entry_addr(in_sel, in_cnt[IW-1:0]);
                                ram_req.wr_data = s_tdata;
                                count_next[in_sel] = in_cnt + CW'(1);
                            end
                        end
                        tsm_pkg::FUNC_POP:
                        begin
                            if (in_cnt == '0)
                            begin
                                res_stat_next = tsm_pkg::STAT_UNDERFLOW;
                            end
                            else
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = entry_addr(in_sel, IW'(in_cnt - CW'(1)));
                                count_next[in_sel] = in_cnt - CW'(1);
                                res_mem_next = 1'b1;
                            end
                        end
                        tsm_pkg::FUNC_SORT:
                        begin
                            // nothing to do for fewer than two entries
                            if (in_cnt > CW'(1))
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = entry_addr(in_sel, IW'(1));
                                idx_next   = IW'(1);
                                state_next = ST_SORT_V;
                            end
                        end
                        tsm_pkg::FUNC_DISPLAY:
                        begin
                            if (in_cnt == '0)
                            begin
                                res_stat_next = tsm_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = entry_addr(in_sel, IW'(in_cnt - CW'(1)));
                                idx_next      = IW'(in_cnt - CW'(1));
                                res_mem_next  = 1'b1;
                                res_last_next = (in_cnt == CW'(1));
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RESULT:
            begin
                if (slot_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_stat_reg;
                    m_data_next  = res_mem_reg ? ram_rdata : '0;
                    m_last_next  = res_last_reg;
                    // display walks down the stack, one read per result
                    if (func_reg == tsm_pkg::FUNC_DISPLAY && res_mem_reg && !res_last_reg)
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = entry_addr(sel_reg, idx_reg - IW'(1));
                        idx_next        = idx_reg - IW'(1);
                        res_last_next   = (idx_reg == IW'(1));
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SORT_V:
            begin
                // take the key, read its lower neighbor
                v_next          = ram_rdata;
                j_next          = idx_reg;
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = entry_addr(sel_reg, idx_reg - IW'(1));
                state_next      = ST_SORT_CMP;
            end

            ST_SORT_CMP, ST_SORT_PUT:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = entry_addr(sel_reg, j_reg);
                if (state_reg == ST_SORT_CMP && ram_rdata < v_reg)
                begin
                    // shift the smaller word up one place
                    ram_req.wr_data = ram_rdata;
                    j_next          = j_minus;
                    if (j_reg == IW'(1))
                    begin
                        state_next = ST_SORT_PUT;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = entry_addr(sel_reg, j_minus - IW'(1));
                    end
                end
                else
                begin
                    // drop the key into the hole; advance the outer index unless it was the last
                    ram_req.wr_data = v_reg;
                    if (CW'(idx_reg) + CW'(1) == cur_cnt)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        idx_next        = i_plus;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = entry_addr(sel_reg, i_plus);
                        state_next      = ST_SORT_V;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < tsm_pkg::NUM_STACKS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        sel_reg      <= sel_next;
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        v_reg        <= v_next;
        res_stat_reg <= res_stat_next;
        res_mem_reg  <= res_mem_next;
        res_last_reg <= res_last_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire
